// File: rtl/frx_pkg.sv
`timescale 1ns / 1ps

package frx_pkg;

  localparam int WINDOW_SLOTS = 16;
  localparam int SLOT_W       = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int OCC_W        = $clog2(WINDOW_SLOTS + 1);
  localparam int LIMIT_W      = 5;
  localparam int CMP_W        = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 8;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_CODE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NAK_CODE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_XON_CODE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_XOFF_CODE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_END_MARKER  = 3'd6;

  localparam logic [LIMIT_W-1:0] UPPER_LIMIT_RST = 5'd10;
  localparam logic [LIMIT_W-1:0] LOWER_LIMIT_RST = 5'd2;
  localparam logic [7:0]         ACK_CODE_RST    = 8'd6;
  localparam logic [7:0]         NAK_CODE_RST    = 8'd21;
  localparam logic [7:0]         XON_CODE_RST    = 8'd17;
  localparam logic [7:0]         XOFF_CODE_RST   = 8'd19;
  localparam logic [7:0]         END_MARKER_RST  = 8'd26;

  localparam logic OP_FRAME   = 1'b0;
  localparam logic OP_CONSUME = 1'b1;

  typedef enum logic [2:0] {
    KIND_ACK   = 3'd0,
    KIND_NAK   = 3'd1,
    KIND_XOFF  = 3'd2,
    KIND_XON   = 3'd3,
    KIND_DATA  = 3'd4,
    KIND_EMPTY = 3'd5
  } kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_SECOND
  } back_state_t;

  // classified item as it sits in the queue
  typedef struct packed {
    logic        opcode;
    logic        chk_ok;
    logic [15:0] number;
    logic [23:0] payload;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  code_byte;
    logic [15:0] reply_number;
    logic [2:0]  reply_check;
    logic [7:0]  data_0;
    logic [7:0]  data_1;
    logic [7:0]  data_2;
    logic [1:0]  end_position;
    logic        last;
  } result_t;

  // ack/nak reply with its packed check bits
  function automatic result_t make_reply(kind_t kind, logic [7:0] code, logic [15:0] num);
    result_t r;
    r = '0;
    r.kind         = kind;
    r.code_byte    = code;
    r.reply_number = num;
    r.reply_check  = {code[0], num[8], num[0]};
    return r;
  endfunction

  function automatic result_t make_flow(kind_t kind, logic [7:0] code);
    result_t r;
    r = '0;
    r.kind      = kind;
    r.code_byte = code;
    return r;
  endfunction

endpackage

// File: rtl/frx_front.sv
`timescale 1ns / 1ps

module frx_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_opcode,
  input  logic [7:0]        in_head_byte,
  input  logic [7:0]        in_number_high,
  input  logic [7:0]        in_number_low,
  input  logic [7:0]        in_spare_byte_a,
  input  logic [7:0]        in_payload_0,
  input  logic [7:0]        in_payload_1,
  input  logic [7:0]        in_payload_2,
  input  logic [7:0]        in_spare_byte_b,
  input  logic [7:0]        in_frame_check,
  output logic              q_valid,
  output frx_pkg::item_t    q_item,
  input  logic              q_pop
);

  frx_pkg::item_t q_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           push;
  frx_pkg::item_t cls;
  logic [7:0]     packed_chk;

  // low bit of each of bytes 0..7, byte 0 in the msb
  assign packed_chk = {in_head_byte[0], in_number_high[0], in_number_low[0],
                       in_spare_byte_a[0], in_payload_0[0], in_payload_1[0],
                       in_payload_2[0], in_spare_byte_b[0]};

  always_comb begin
    cls.opcode  = in_opcode;
    cls.chk_ok  = (packed_chk == in_frame_check);
    cls.number  = {in_number_high, in_number_low};
    cls.payload = {in_payload_0, in_payload_1, in_payload_2};
  end

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// File: rtl/frx_back.sv
`timescale 1ns / 1ps

module frx_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [frx_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [frx_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                q_valid,
  input  frx_pkg::item_t                      q_item,
  output logic                                q_pop,
  output logic                                res_valid,
  input  logic                                res_ready,
  output frx_pkg::result_t                    res
);

  localparam int SLOT_W = frx_pkg::SLOT_W;
  localparam int OCC_W  = frx_pkg::OCC_W;
  localparam int CMP_W  = frx_pkg::CMP_W;

  // config registers
  logic [frx_pkg::LIMIT_W-1:0] upper_limit_r, lower_limit_r;
  logic [7:0] ack_code_r, nak_code_r, xon_code_r, xoff_code_r, end_marker_r;

  // window state
  logic [23:0]       slot_payload_r [frx_pkg::WINDOW_SLOTS];
  logic [frx_pkg::WINDOW_SLOTS-1:0] slot_valid_r;
  logic [15:0]       next_exp_r, next_exp_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic              stopped_r, stopped_nxt;
  logic [SLOT_W-1:0] head_r, head_nxt;

  frx_pkg::back_state_t state_r, state_nxt;
  frx_pkg::result_t     out_r, pend_r;
  logic                 out_valid_r, out_valid_nxt;

  logic              out_free, do_proc, load_a, load_b;
  logic [15:0]       off;
  logic              in_win;
  logic [SLOT_W:0]   slot_sum;
  logic [SLOT_W-1:0] slot;
  logic              store_en, deliver_en, two_res, any_res;
  frx_pkg::result_t  res_a, res_b;
  logic [23:0]       head_data;
  logic [7:0]        d0, d1, d2;

  assign out_free = !out_valid_r || res_ready;
  assign do_proc  = (state_r == frx_pkg::BK_IDLE) && q_valid && out_free;

  assign off      = q_item.number - next_exp_r;
  assign in_win   = (off < 16'(frx_pkg::WINDOW_SLOTS));
  // head + offset wraps around the window, sum stays below twice its size
  assign slot_sum = {1'b0, head_r} + {1'b0, off[SLOT_W-1:0]};
  assign slot     = (slot_sum >= (SLOT_W+1)'(frx_pkg::WINDOW_SLOTS)) ?
                    SLOT_W'(slot_sum - (SLOT_W+1)'(frx_pkg::WINDOW_SLOTS)) :
                    slot_sum[SLOT_W-1:0];

  assign head_data = slot_payload_r[head_r];
  assign d0 = head_data[23:16];
  assign d1 = head_data[15:8];
  assign d2 = head_data[7:0];

  always_comb begin
    res_a        = '0;
    res_b        = '0;
    two_res      = 1'b0;
    any_res      = 1'b0;
    store_en     = 1'b0;
    deliver_en   = 1'b0;
    occ_nxt      = occ_r;
    stopped_nxt  = stopped_r;
    next_exp_nxt = next_exp_r;
    head_nxt     = head_r;
    if (q_item.opcode == frx_pkg::OP_FRAME) begin
      if (!stopped_r) begin
        any_res = 1'b1;
        if (q_item.chk_ok && in_win) begin
          res_a    = frx_pkg::make_reply(frx_pkg::KIND_ACK, ack_code_r, q_item.number);
          store_en = !slot_valid_r[slot];
          occ_nxt  = occ_r + OCC_W'(store_en);
        end else begin
          res_a = frx_pkg::make_reply(frx_pkg::KIND_NAK, nak_code_r, q_item.number);
        end
        if (CMP_W'(occ_nxt) > CMP_W'(upper_limit_r)) begin
          stopped_nxt = 1'b1;
          two_res     = 1'b1;
          res_b       = frx_pkg::make_flow(frx_pkg::KIND_XOFF, xoff_code_r);
        end
      end
    end else begin
      any_res = 1'b1;
      if (occ_r == '0) begin
        res_b = frx_pkg::make_flow(frx_pkg::KIND_EMPTY, 8'd0);
      end else if (!slot_valid_r[head_r]) begin
        res_b = frx_pkg::make_reply(frx_pkg::KIND_NAK, nak_code_r, next_exp_r);
      end else begin
        deliver_en         = 1'b1;
        res_b              = '0;
        res_b.kind         = frx_pkg::KIND_DATA;
        res_b.reply_number = next_exp_r;
        res_b.data_0       = d0;
        res_b.data_1       = d1;
        res_b.data_2       = d2;
        if (d0 == end_marker_r)      res_b.end_position = 2'd1;
        else if (d1 == end_marker_r) res_b.end_position = 2'd2;
        else if (d2 == end_marker_r) res_b.end_position = 2'd3;
        else                         res_b.end_position = 2'd0;
        occ_nxt      = occ_r - OCC_W'(1);
        next_exp_nxt = next_exp_r + 16'd1;
        head_nxt     = (head_r == SLOT_W'(frx_pkg::WINDOW_SLOTS - 1)) ?
                       '0 : head_r + SLOT_W'(1);
      end
      // xon goes out ahead of the consume result
      if (stopped_r && (CMP_W'(occ_r) < CMP_W'(lower_limit_r))) begin
        stopped_nxt = 1'b0;
        two_res     = 1'b1;
        res_a       = frx_pkg::make_flow(frx_pkg::KIND_XON, xon_code_r);
      end else begin
        res_a = res_b;
      end
    end
    if (two_res) begin
      res_b.last = 1'b1;
    end else begin
      res_a.last = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      frx_pkg::BK_IDLE: begin
        if (do_proc && two_res) state_nxt = frx_pkg::BK_SECOND;
      end
      frx_pkg::BK_SECOND: begin
        if (out_free) state_nxt = frx_pkg::BK_IDLE;
      end
      default: state_nxt = frx_pkg::BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    load_a = 1'b0;
    load_b = 1'b0;
    q_pop  = 1'b0;
    case (state_r)
      frx_pkg::BK_IDLE: begin
        q_pop  = do_proc;
        load_a = do_proc && any_res;
      end
      frx_pkg::BK_SECOND: begin
        load_b = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (load_a || load_b) out_valid_nxt = 1'b1;
    else if (res_ready)   out_valid_nxt = 1'b0;
    else                  out_valid_nxt = out_valid_r;
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_limit_r <= frx_pkg::UPPER_LIMIT_RST;
      lower_limit_r <= frx_pkg::LOWER_LIMIT_RST;
      ack_code_r    <= frx_pkg::ACK_CODE_RST;
      nak_code_r    <= frx_pkg::NAK_CODE_RST;
      xon_code_r    <= frx_pkg::XON_CODE_RST;
      xoff_code_r   <= frx_pkg::XOFF_CODE_RST;
      end_marker_r  <= frx_pkg::END_MARKER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        frx_pkg::REG_UPPER_LIMIT: upper_limit_r <= cfg_data[frx_pkg::LIMIT_W-1:0];
        frx_pkg::REG_LOWER_LIMIT: lower_limit_r <= cfg_data[frx_pkg::LIMIT_W-1:0];
        frx_pkg::REG_ACK_CODE:    ack_code_r    <= cfg_data;
        frx_pkg::REG_NAK_CODE:    nak_code_r    <= cfg_data;
        frx_pkg::REG_XON_CODE:    xon_code_r    <= cfg_data;
        frx_pkg::REG_XOFF_CODE:   xoff_code_r   <= cfg_data;
        frx_pkg::REG_END_MARKER:  end_marker_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= frx_pkg::BK_IDLE;
      out_valid_r  <= 1'b0;
      slot_valid_r <= '0;
      next_exp_r   <= 16'd0;
      occ_r        <= '0;
      stopped_r    <= 1'b0;
      head_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (do_proc) begin
        next_exp_r <= next_exp_nxt;
        occ_r      <= occ_nxt;
        stopped_r  <= stopped_nxt;
        head_r     <= head_nxt;
        if (store_en)   slot_valid_r[slot]   <= 1'b1;
        if (deliver_en) slot_valid_r[head_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_proc && store_en) begin
      slot_payload_r[slot] <= q_item.payload;
    end
    if (load_a) begin
      out_r  <= res_a;
      pend_r <= res_b;
    end else if (load_b) begin
      out_r <= pend_r;
    end
  end

endmodule

// File: rtl/frame_receiver_with_xon_xoff.sv
`timescale 1ns / 1ps
// With an empty queue and a free output, an accepted item is written to the front queue
// and its result then to the output register; a second result of the same item waits
// in a pending register until the output is free. Throughput: one result per cycle from
// the back end while out_ready is high; an item with two results (ack/nak + xoff, xon
// + consume) keeps it in BK_SECOND. A two-entry queue between front and back absorbs it.
// Reset (rst_n, synchronous): queue and output empty, window cleared, config at defaults.
module frame_receiver_with_xon_xoff (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [frx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [frx_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_opcode,
  input  logic [7:0]                     in_head_byte,
  input  logic [7:0]                     in_number_high,
  input  logic [7:0]                     in_number_low,
  input  logic [7:0]                     in_spare_byte_a,
  input  logic [7:0]                     in_payload_0,
  input  logic [7:0]                     in_payload_1,
  input  logic [7:0]                     in_payload_2,
  input  logic [7:0]                     in_spare_byte_b,
  input  logic [7:0]                     in_frame_check,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     out_kind,
  output logic [7:0]                     out_code_byte,
  output logic [15:0]                    out_reply_number,
  output logic [2:0]                     out_reply_check,
  output logic [7:0]                     out_data_0,
  output logic [7:0]                     out_data_1,
  output logic [7:0]                     out_data_2,
  output logic [1:0]                     out_end_position,
  output logic                           out_last
);

  logic             q_valid, q_pop;
  frx_pkg::item_t   q_item;
  frx_pkg::result_t res;

  frx_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_head_byte    (in_head_byte),
    .in_number_high  (in_number_high),
    .in_number_low   (in_number_low),
    .in_spare_byte_a (in_spare_byte_a),
    .in_payload_0    (in_payload_0),
    .in_payload_1    (in_payload_1),
    .in_payload_2    (in_payload_2),
    .in_spare_byte_b (in_spare_byte_b),
    .in_frame_check  (in_frame_check),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  frx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  assign out_kind         = res.kind;
  assign out_code_byte    = res.code_byte;
  assign out_reply_number = res.reply_number;
  assign out_reply_check  = res.reply_check;
  assign out_data_0       = res.data_0;
  assign out_data_1       = res.data_1;
  assign out_data_2       = res.data_2;
  assign out_end_position = res.end_position;
  assign out_last         = res.last;

endmodule
